FILE: rtl/crmsd_pkg.sv
// Shared sizes, constants and controller/datapath handshake types for the
// coordinate RMSD accumulator. No dependencies; every other rtl file imports it.
package crmsd_pkg;

  // Input coordinate format: signed, 12 fraction bits
  localparam int COORD_BITS = 20;
  localparam int MAX_POINTS = 65536;
  localparam int COUNT_BITS = 17;
  localparam int SUM_BITS   = 60;
  localparam int DEV_BITS   = 21;
  localparam int IN_BITS    = 6 * COORD_BITS;
  localparam int OUT_BITS   = 40;

  // Derived datapath widths
  localparam int MAG_BITS   = COORD_BITS + 1;
  localparam int SQ_BITS    = 2 * MAG_BITS;
  localparam int SUM3_BITS  = SQ_BITS + 2;
  localparam int ROOT_BITS  = SUM_BITS / 2;
  localparam int DIV_CNT_BITS  = $clog2(SUM_BITS);
  localparam int ROOT_CNT_BITS = $clog2(ROOT_BITS);

  localparam logic [COUNT_BITS-1:0] COUNT_FULL = COUNT_BITS'(MAX_POINTS);
  localparam logic [SUM_BITS-1:0]   SUM_MAX    = {SUM_BITS{1'b1}};
  localparam logic [DEV_BITS-1:0]   DEV_MAX    = {DEV_BITS{1'b1}};

  // Commands from the controller to the datapath
  typedef struct packed {
    logic take;        // accept the presented item into the pipeline
    logic div_start;   // latch sum and count, clear the accumulators
    logic root_start;  // start the square root on the quotient
    logic out_load;    // load the result into the output register
  } crmsd_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic pipe_busy;   // squares still in flight
    logic div_done;    // divider finished this cycle
    logic root_done;   // root unit finished this cycle
    logic out_full;    // output register holds an untaken item
  } crmsd_status_t;

endpackage

FILE: rtl/crmsd_div.sv
// Restoring divider, one quotient bit per cycle: sum / count.
// Depends on crmsd_pkg.
module crmsd_div
  import crmsd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [SUM_BITS-1:0]   dividend,
  input  logic [COUNT_BITS-1:0] divisor,
  output logic                  done,
  output logic [SUM_BITS-1:0]   quotient
);

  localparam logic [DIV_CNT_BITS-1:0] LAST_STEP = DIV_CNT_BITS'(SUM_BITS - 1);

  logic                    busy;
  logic [DIV_CNT_BITS-1:0] cnt;
  logic [COUNT_BITS-1:0]   dsr;
  logic [COUNT_BITS-1:0]   rem;
  logic [COUNT_BITS:0]     shifted;
  logic [COUNT_BITS:0]     diff;

  // Trial subtract of the divisor from the shifted remainder
  always_comb begin
    shifted = {rem, quotient[SUM_BITS-1]};
    diff    = shifted - {1'b0, dsr};
  end

  // Control: busy flag, step count
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift the quotient in where the dividend shifts out
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      dsr      <= divisor;
      rem      <= '0;
    end else if (busy) begin
      if (!diff[COUNT_BITS]) begin
        rem      <= diff[COUNT_BITS-1:0];
        quotient <= {quotient[SUM_BITS-2:0], 1'b1};
      end else begin
        rem      <= shifted[COUNT_BITS-1:0];
        quotient <= {quotient[SUM_BITS-2:0], 1'b0};
      end
    end
  end

endmodule

FILE: rtl/crmsd_sqrt.sv
// Digit-by-digit floor square root, one root bit per cycle.
// Depends on crmsd_pkg.
module crmsd_sqrt
  import crmsd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [SUM_BITS-1:0]  radicand,
  output logic                 done,
  output logic [ROOT_BITS-1:0] root
);

  localparam int REM_BITS = ROOT_BITS + 2;
  localparam logic [ROOT_CNT_BITS-1:0] LAST_STEP = ROOT_CNT_BITS'(ROOT_BITS - 1);

  logic                     busy;
  logic [ROOT_CNT_BITS-1:0] cnt;
  logic [SUM_BITS-1:0]      src;
  logic [REM_BITS-1:0]      rem;
  logic [REM_BITS+1:0]      cur;
  logic [REM_BITS+1:0]      trial;
  logic [REM_BITS+1:0]      diff;

  // Bring down two radicand bits, try root*4+1
  always_comb begin
    cur   = {rem, src[SUM_BITS-1 -: 2]};
    trial = {2'b00, root, 2'b01};
    diff  = cur - trial;
  end

  // Control: busy flag, step count
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: one root bit per step
  always_ff @(posedge clk) begin
    if (start) begin
      src  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      src <= {src[SUM_BITS-3:0], 2'b00};
      if (cur >= trial) begin
        rem  <= diff[REM_BITS-1:0];
        root <= {root[ROOT_BITS-2:0], 1'b1};
      end else begin
        rem  <= cur[REM_BITS-1:0];
        root <= {root[ROOT_BITS-2:0], 1'b0};
      end
    end
  end

endmodule

FILE: rtl/crmsd_datapath.sv
// Datapath: squared-distance pipeline, accumulators, divide, root, output register.
// Depends on crmsd_pkg, crmsd_div and crmsd_sqrt.
module crmsd_datapath
  import crmsd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  crmsd_cmd_t            cmd,
  output crmsd_status_t         status,
  input  logic [IN_BITS-1:0]    in_data,
  output logic [OUT_BITS-1:0]   out_data,
  output logic                  out_flag,
  input  logic                  out_taken
);

  logic [MAG_BITS-1:0]   mag [3];
  logic [MAG_BITS-1:0]   mag_q [3];
  logic [SQ_BITS-1:0]    sq_q [3];
  logic [SUM3_BITS-1:0]  sum3_q;
  logic                  a_valid;
  logic                  b_valid;
  logic                  c_valid;
  logic [SUM_BITS-1:0]   squared_sum;
  logic [SUM_BITS:0]     sum_wide;
  logic [COUNT_BITS-1:0] pair_count;
  logic                  overflow_seen;
  logic                  count_full;
  logic [COUNT_BITS-1:0] hold_total;
  logic                  hold_ovf;
  logic [SUM_BITS-1:0]   quotient;
  logic [ROOT_BITS-1:0]  root;
  logic [DEV_BITS-1:0]   dev_sat;
  logic                  out_full;

  // Per-axis difference magnitude
  always_comb begin
    logic [COORD_BITS-1:0] a;
    logic [COORD_BITS-1:0] b;
    logic [COORD_BITS:0]   d;
    for (int i = 0; i < 3; i++) begin
      a = in_data[i*COORD_BITS +: COORD_BITS];
      b = in_data[(i+3)*COORD_BITS +: COORD_BITS];
      d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
      mag[i] = d[COORD_BITS] ? (~d + 1'b1) : d;
    end
  end

  assign count_full = (pair_count == COUNT_FULL);
  assign sum_wide   = {1'b0, squared_sum} + (SUM_BITS+1)'(sum3_q);

  // Pipeline valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      a_valid <= cmd.take && !count_full;
      b_valid <= a_valid;
      c_valid <= b_valid;
    end
  end

  // Pipeline payload: magnitudes, squares, three-axis sum
  always_ff @(posedge clk) begin
    mag_q <= mag;
    for (int i = 0; i < 3; i++) begin
      sq_q[i] <= mag_q[i] * mag_q[i];
    end
    sum3_q <= SUM3_BITS'(sq_q[0]) + SUM3_BITS'(sq_q[1]) + SUM3_BITS'(sq_q[2]);
  end

  // Accumulators; clear when the divide takes the set
  always_ff @(posedge clk) begin
    if (rst || cmd.div_start) begin
      squared_sum   <= '0;
      pair_count    <= '0;
      overflow_seen <= 1'b0;
    end else begin
      if (cmd.take) begin
        if (count_full) overflow_seen <= 1'b1;
        else            pair_count    <= pair_count + 1'b1;
      end
      if (c_valid) begin
        squared_sum <= sum_wide[SUM_BITS] ? SUM_MAX : sum_wide[SUM_BITS-1:0];
      end
    end
  end

  // Hold count and overflow of the set under computation
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      hold_total <= pair_count;
      hold_ovf   <= overflow_seen;
    end
  end

  crmsd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (squared_sum),
    .divisor  (pair_count),
    .done     (status.div_done),
    .quotient (quotient)
  );

  crmsd_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.root_start),
    .radicand (quotient),
    .done     (status.root_done),
    .root     (root)
  );

  assign dev_sat = (root > ROOT_BITS'(DEV_MAX)) ? DEV_MAX : root[DEV_BITS-1:0];

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (cmd.out_load) begin
      out_full <= 1'b1;
    end else if (out_taken) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= {(OUT_BITS-DEV_BITS-COUNT_BITS)'(0), hold_total, dev_sat};
      out_flag <= hold_ovf;
    end
  end

  assign status.pipe_busy = a_valid || b_valid || c_valid;
  assign status.out_full  = out_full;

endmodule

FILE: rtl/crmsd_ctrl.sv
// Controller: accumulate, drain, divide, root, hand over to the output register.
// Depends on crmsd_pkg.
module crmsd_ctrl
  import crmsd_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_last,
  output logic          in_ready,
  output crmsd_cmd_t    cmd,
  input  crmsd_status_t status
);

  localparam logic [2:0] ST_ACCUM  = 3'd0;
  localparam logic [2:0] ST_DRAIN  = 3'd1;
  localparam logic [2:0] ST_DIV    = 3'd2;
  localparam logic [2:0] ST_ROOT   = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == ST_ACCUM);

  // Next state and commands
  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.take       = in_ready && in_valid;
    unique case (state)
      ST_ACCUM: begin
        if (in_valid && in_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV;
        end
      end
      ST_DIV: begin
        if (status.div_done) begin
          cmd.root_start = 1'b1;
          state_next     = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (status.root_done) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!status.out_full) begin
          cmd.out_load = 1'b1;
          state_next   = ST_ACCUM;
        end
      end
      default: state_next = ST_ACCUM;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_ACCUM;
    else     state <= state_next;
  end

endmodule

FILE: rtl/coordinate_rmsd_accumulator_core.sv
// Top level of the coordinate RMSD accumulator: controller plus datapath.
// Depends on crmsd_pkg, crmsd_ctrl and crmsd_datapath.
//
//   Channel  Dir  Payload
//   s_axis   in   tdata: six 20-bit signed coordinates; tlast: final pair
//   m_axis   out  tdata: deviation, pair count; tuser: overflow
//
// Pairs are taken one per cycle while a set accumulates; the squared
// distance pipeline is three registers deep and feeds the sum.
// After the final pair the block drains the pipeline, runs the 60-step
// divider and the 30-step root and loads the output register; s_axis_tready
// stays low through these steps, so the next set may start only after the load.
// A result waits in the output register; a further result waits for it.
// Reset clears the accumulators, the pipeline and the output register.
module coordinate_rmsd_accumulator_core
  import crmsd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z (20 bits each)
  input  logic [IN_BITS-1:0]  s_axis_tdata,
  input  logic                s_axis_tlast,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // deviation [20:0], pair_total [37:21], zero fill [39:38]
  output logic [OUT_BITS-1:0] m_axis_tdata,
  // overflow [0]
  output logic                m_axis_tuser
);

  crmsd_cmd_t    cmd;
  crmsd_status_t status;

  crmsd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_last  (s_axis_tlast),
    .in_ready (s_axis_tready),
    .cmd      (cmd),
    .status   (status)
  );

  crmsd_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (s_axis_tdata),
    .out_data  (m_axis_tdata),
    .out_flag  (m_axis_tuser),
    .out_taken (m_axis_tvalid && m_axis_tready)
  );

  assign m_axis_tvalid = status.out_full;

endmodule
